/* rtl/core/iorb_pkg.sv */
// Package for the in-order release buffer: widths, window size, register
// indexes, state encoding and the structs passed between the core modules.
// No dependencies.
`timescale 1ns / 1ps

package iorb_pkg;

    // Window and field widths
    localparam int WINDOW  = 64;
    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int SEQ_W   = 16;
    localparam int EXP_W   = SEQ_W + 1;
    localparam int PAY_W   = 32;
    localparam int DATA_W  = SEQ_W + PAY_W;
    localparam int USER_W  = 2;
    localparam int APB_DW  = 32;
    localparam int ADDR_W  = 3;
    localparam int REGI_W  = ADDR_W - 2;

    // Register map, indexed by paddr[ADDR_W-1:2]
    localparam logic [REGI_W-1:0] REG_FIRST_SEQ = 1'b0;
    localparam logic [REGI_W-1:0] REG_LAST_SEQ  = 1'b1;

    // Register reset values
    localparam logic [SEQ_W-1:0] FIRST_SEQ_RST = 16'd1;
    localparam logic [SEQ_W-1:0] LAST_SEQ_RST  = 16'hFFFF;

    // Result status codes
    localparam logic STATUS_RELEASED = 1'b0;
    localparam logic STATUS_DROPPED  = 1'b1;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_RELEASE
    } state_t;

    // Configuration handed from the register block to the controller
    typedef struct packed {
        logic             restart;
        logic [SEQ_W-1:0] first_seq;
        logic [SEQ_W-1:0] last_seq;
    } cfg_t;

    // Request to the slot payload memory
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [PAY_W-1:0]  wr_data;
        logic [SLOT_W-1:0] rd_addr;
    } ram_req_t;

endpackage

/* rtl/core/iorb_slot_ram.sv */
// Slot payload memory of the in-order release buffer: one write port and
// one read port with registered read data. Depends on iorb_pkg.
`timescale 1ns / 1ps

module iorb_slot_ram (
    input  logic                    aclk,
    input  iorb_pkg::ram_req_t      req,
    output logic [iorb_pkg::PAY_W-1:0] rd_data
);

    logic [iorb_pkg::PAY_W-1:0] mem [iorb_pkg::WINDOW];

    // Write port.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge aclk) begin
        rd_data <= mem[req.rd_addr];
    end

endmodule

/* rtl/core/iorb_cfg.sv */
// APB register block of the in-order release buffer: first_seq and
// last_seq, with a restart pulse on every first_seq write. Depends on iorb_pkg.
`timescale 1ns / 1ps

module iorb_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [iorb_pkg::ADDR_W-1:0] paddr,
    input  logic [iorb_pkg::APB_DW-1:0] pwdata,
    output logic [iorb_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output iorb_pkg::cfg_t              cfg
);

    logic [iorb_pkg::SEQ_W-1:0]  first_seq_reg;
    logic [iorb_pkg::SEQ_W-1:0]  last_seq_reg;
    logic [iorb_pkg::REGI_W-1:0] reg_idx;
    logic                        wr_fire;

    assign pready  = 1'b1;
    assign reg_idx = paddr[iorb_pkg::ADDR_W-1:2];
    assign wr_fire = psel && penable && pwrite && pready;

    // Register writes; only the low 16 bits of the data are kept.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_seq_reg <= iorb_pkg::FIRST_SEQ_RST;
            last_seq_reg  <= iorb_pkg::LAST_SEQ_RST;
        end else if (wr_fire) begin
            case (reg_idx)
                iorb_pkg::REG_FIRST_SEQ: begin
                    first_seq_reg <= pwdata[iorb_pkg::SEQ_W-1:0];
                end
                iorb_pkg::REG_LAST_SEQ: begin
                    last_seq_reg <= pwdata[iorb_pkg::SEQ_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read mux.
    always_comb begin
        case (reg_idx)
            iorb_pkg::REG_FIRST_SEQ: begin
                prdata = {{(iorb_pkg::APB_DW - iorb_pkg::SEQ_W){1'b0}}, first_seq_reg};
            end
            iorb_pkg::REG_LAST_SEQ: begin
                prdata = {{(iorb_pkg::APB_DW - iorb_pkg::SEQ_W){1'b0}}, last_seq_reg};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // The restart pulse comes straight from the write strobe so that the
    // controller loads the new number at the same edge as the register.
    always_comb begin
        cfg.restart   = wr_fire && (reg_idx == iorb_pkg::REG_FIRST_SEQ);
        cfg.first_seq = pwdata[iorb_pkg::SEQ_W-1:0];
        cfg.last_seq  = last_seq_reg;
    end

endmodule

/* rtl/core/iorb_ctrl.sv */
// Controller of the in-order release buffer: window check, slot valid bits,
// expected number, release sequencer and output register. Depends on iorb_pkg.
`timescale 1ns / 1ps

module iorb_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  iorb_pkg::cfg_t              cfg,
    // Input beats
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [iorb_pkg::SEQ_W-1:0]  in_seq,
    input  logic [iorb_pkg::PAY_W-1:0]  in_payload,
    // Slot memory
    output iorb_pkg::ram_req_t          ram_req,
    input  logic [iorb_pkg::PAY_W-1:0]  ram_rd_data,
    // Result beats
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [iorb_pkg::SEQ_W-1:0]  out_seq,
    output logic [iorb_pkg::PAY_W-1:0]  out_payload,
    output logic                        out_status,
    output logic                        out_last,
    output logic                        out_done
);

    localparam int SEQ_W  = iorb_pkg::SEQ_W;
    localparam int EXP_W  = iorb_pkg::EXP_W;
    localparam int PAY_W  = iorb_pkg::PAY_W;
    localparam int SLOT_W = iorb_pkg::SLOT_W;

    iorb_pkg::state_t          state_reg, state_next;
    logic [SEQ_W-1:0]          seq_reg;
    logic [PAY_W-1:0]          pay_reg;
    logic [EXP_W-1:0]          exp_reg, exp_next;
    logic [iorb_pkg::WINDOW-1:0] valid_reg, valid_next;

    logic                      out_valid_reg, out_valid_next;
    logic [SEQ_W-1:0]          out_seq_reg, out_seq_next;
    logic [PAY_W-1:0]          out_pay_reg, out_pay_next;
    logic                      out_status_reg, out_status_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_done_reg, out_done_next;

    logic [EXP_W-1:0]          seq_ext;
    logic [EXP_W-1:0]          diff;
    logic [EXP_W-1:0]          exp_inc;
    logic                      in_window;
    logic                      at_expected;
    logic                      more;
    logic                      out_free;
    logic                      load_out;

    // Window check on the captured item and the release continuation test.
    assign seq_ext     = {1'b0, seq_reg};
    assign diff        = seq_ext - exp_reg;
    assign in_window   = (seq_ext >= exp_reg) && (diff[EXP_W-1:SLOT_W] == '0);
    assign at_expected = (seq_ext == exp_reg);
    assign exp_inc     = exp_reg + 1'b1;
    assign more        = !exp_inc[EXP_W-1] && valid_reg[exp_inc[SLOT_W-1:0]];
    assign out_free    = !out_valid_reg || out_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            iorb_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = iorb_pkg::ST_CHECK;
                end
            end
            iorb_pkg::ST_CHECK: begin
                if (!in_window) begin
                    if (out_free) begin
                        state_next = iorb_pkg::ST_IDLE;
                    end
                end else if (at_expected) begin
                    state_next = iorb_pkg::ST_READ;
                end else begin
                    state_next = iorb_pkg::ST_IDLE;
                end
            end
            iorb_pkg::ST_READ: begin
                state_next = iorb_pkg::ST_RELEASE;
            end
            iorb_pkg::ST_RELEASE: begin
                if (out_free && !more) begin
                    state_next = iorb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = iorb_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs per state.
    always_comb begin
        exp_next        = exp_reg;
        valid_next      = valid_reg;
        load_out        = 1'b0;
        out_seq_next    = out_seq_reg;
        out_pay_next    = out_pay_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = seq_reg[SLOT_W-1:0];
        ram_req.wr_data = pay_reg;
        in_ready        = 1'b0;

        case (state_reg)
            iorb_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            iorb_pkg::ST_CHECK: begin
                if (in_window) begin
                    // Store the payload and mark its slot.
                    ram_req.wr_en = 1'b1;
                    valid_next[seq_reg[SLOT_W-1:0]] = 1'b1;
                end else if (out_free) begin
                    // Stale or too far ahead: report a drop.
                    load_out        = 1'b1;
                    out_seq_next    = seq_reg;
                    out_pay_next    = '0;
                    out_status_next = iorb_pkg::STATUS_DROPPED;
                    out_last_next   = 1'b1;
                    out_done_next   = exp_reg > {1'b0, cfg.last_seq};
                end
            end
            iorb_pkg::ST_RELEASE: begin
                if (out_free) begin
                    // Release the expected slot and advance.
                    load_out        = 1'b1;
                    out_seq_next    = exp_reg[SEQ_W-1:0];
                    out_pay_next    = ram_rd_data;
                    out_status_next = iorb_pkg::STATUS_RELEASED;
                    out_last_next   = !more;
                    out_done_next   = exp_inc > {1'b0, cfg.last_seq};
                    valid_next[exp_reg[SLOT_W-1:0]] = 1'b0;
                    exp_next        = exp_inc;
                end
            end
            default: begin
            end
        endcase

        // A first_seq write restarts the window; the user must issue it only while idle, the block does not enforce it.
        if (cfg.restart) begin
            exp_next   = {1'b0, cfg.first_seq};
            valid_next = '0;
        end

        // The read address follows the expected number of the next cycle, so the
        // payload of that slot is registered in the read data as that number is registered.
        ram_req.rd_addr = exp_next[SLOT_W-1:0];

        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= iorb_pkg::ST_IDLE;
            exp_reg       <= {1'b0, iorb_pkg::FIRST_SEQ_RST};
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            seq_reg <= in_seq;
            pay_reg <= in_payload;
        end
        out_seq_reg    <= out_seq_next;
        out_pay_reg    <= out_pay_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_done_reg   <= out_done_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_seq     = out_seq_reg;
    assign out_payload = out_pay_reg;
    assign out_status  = out_status_reg;
    assign out_last    = out_last_reg;
    assign out_done    = out_done_reg;

endmodule

/* rtl/core/in_order_release_buffer.sv */
// In-order release buffer with a 64-slot sequence window.
// Items enter on the s_ stream as (seq, payload) beats in any order and leave
// on the m_ stream in ascending sequence order, starting at first_seq.
// Each beat is stored at slot seq mod 64; when it fills the expected slot,
// the run of consecutive stored slots is released, one result beat per slot,
// and the final beat of the run carries tlast. A beat behind the expected
// number, or 64 or more ahead of it, yields one drop beat (tuser[0] high,
// zero payload). tuser[1] reports that the expected number has passed last_seq.
// Flow: s_tready is low from acceptance until the block is idle again. A beat
// that only stores passes the check state and returns to idle. A beat that
// starts a run passes the check state, a read state for the registered slot
// memory read and a release state that gives one result beat per cycle while
// m_tready allows. A drop beat loads its result in the check state when free.
// Registers on APB: first_seq at 0x0 (write restarts the window and clears
// all slots), last_seq at 0x4. Write them only while the block is idle.
// Reset clears all slot valid bits at once and sets first_seq to 1 and
// last_seq to 65535. When m_tready is low the result is held in the output
// register and the release run pauses until it is taken.
// Depends on iorb_pkg, iorb_cfg, iorb_ctrl and iorb_slot_ram.
`timescale 1ns / 1ps

module in_order_release_buffer (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [iorb_pkg::DATA_W-1:0] s_tdata,   // seq[15:0], payload[47:16]
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [iorb_pkg::DATA_W-1:0] m_tdata,   // out_seq[15:0], out_payload[47:16]
    output logic [iorb_pkg::USER_W-1:0] m_tuser,   // status[0], done_res[1]
    output logic                        m_tlast,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [iorb_pkg::ADDR_W-1:0] paddr,
    input  logic [iorb_pkg::APB_DW-1:0] pwdata,
    output logic [iorb_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    iorb_pkg::cfg_t                 cfg;
    iorb_pkg::ram_req_t             ram_req;
    logic [iorb_pkg::PAY_W-1:0]     ram_rd_data;
    logic [iorb_pkg::SEQ_W-1:0]     out_seq;
    logic [iorb_pkg::PAY_W-1:0]     out_payload;
    logic                           out_status;
    logic                           out_done;

    // Register block.
    iorb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Window controller and output register.
    iorb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_seq      (s_tdata[iorb_pkg::SEQ_W-1:0]),
        .in_payload  (s_tdata[iorb_pkg::DATA_W-1:iorb_pkg::SEQ_W]),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_seq     (out_seq),
        .out_payload (out_payload),
        .out_status  (out_status),
        .out_last    (m_tlast),
        .out_done    (out_done)
    );

    // Slot payload memory.
    iorb_slot_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    assign m_tdata = {out_payload, out_seq};
    assign m_tuser = {out_done, out_status};

endmodule
